FILE: rtl/core/page_directory_coherence_macros.svh
// Assertion macros used by the page directory checker.
`ifndef PAGE_DIRECTORY_COHERENCE_MACROS_SVH
`define PAGE_DIRECTORY_COHERENCE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PDC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/pdc_pkg.sv
// Shared constants and types of the page directory.
`default_nettype none

package pdc_pkg;

    localparam int NUM_PAGES_DEF   = 256;
    localparam int NUM_CLIENTS_DEF = 8;

    localparam int PAGE_IDX_W = 8;
    localparam int CLIENT_W   = 3;
    localparam int STATUS_W   = 2;
    localparam int KIND_W     = 2;

    // at most this many messages ahead of the reply
    localparam int MAX_PRE_MSGS = 7;
    localparam int PRE_CNT_W    = 3;

    localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHARED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MODIFIED = 2'd2;

    localparam logic [KIND_W-1:0] KIND_FWD      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INV      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INV_DATA = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REPLY    = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CLIENT_W-1:0] target;
        logic                data;
        logic                shared;
        logic                last;
    } msg_t;

endpackage

`default_nettype wire

FILE: rtl/core/pdc_store.sv
// Directory row memory: one row per page, one write and one registered read per cycle.
`default_nettype none

module pdc_store #(
    parameter int NUM_PAGES = pdc_pkg::NUM_PAGES_DEF,
    parameter int ROW_W     = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    rd_en,
    input  wire logic [(NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1)-1:0] rd_addr,
    output logic      [ROW_W-1:0]                        rd_data,
    input  wire logic                                    wr_en,
    input  wire logic [(NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1)-1:0] wr_addr,
    input  wire logic [ROW_W-1:0]                        wr_data
);

    logic [ROW_W-1:0] mem [NUM_PAGES];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pdc_ctrl.sv
// Directory sequencer: clear pass, lookup, write-back and message walk.
`default_nettype none

module pdc_ctrl #(
    parameter int NUM_PAGES   = pdc_pkg::NUM_PAGES_DEF,
    parameter int NUM_CLIENTS = pdc_pkg::NUM_CLIENTS_DEF,
    parameter int ROW_W       = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // request side
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [pdc_pkg::PAGE_IDX_W-1:0]         in_page,
    input  wire logic [pdc_pkg::CLIENT_W-1:0]           in_client,
    input  wire logic                                   in_mode,
    // message side
    output logic                                        msg_valid,
    input  wire logic                                   msg_ready,
    output pdc_pkg::msg_t                               msg,
    // row memory
    output logic                                        mem_rd_en,
    output logic [(NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1)-1:0] mem_rd_addr,
    input  wire logic [ROW_W-1:0]                       mem_rd_data,
    output logic                                        mem_wr_en,
    output logic [(NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1)-1:0] mem_wr_addr,
    output logic [ROW_W-1:0]                            mem_wr_data
);

    localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW = $clog2(NUM_CLIENTS + 1);
    localparam int IW = $clog2(NUM_CLIENTS);
    localparam int KW = pdc_pkg::PRE_CNT_W;

    typedef struct packed {
        logic [pdc_pkg::STATUS_W-1:0]                    status;
        logic [CW-1:0]                                   count;
        logic [NUM_CLIENTS-1:0][pdc_pkg::CLIENT_W-1:0]   list;
    } row_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_PRE,
        S_WALK,
        S_REPLY
    } state_t;

    // page_index mod NUM_PAGES by restoring subtraction of shifted multiples
    function automatic logic [PW-1:0] page_reduce(input logic [pdc_pkg::PAGE_IDX_W-1:0] raw);
        int unsigned v;
        begin
            v = 32'(raw);
            for (int k = pdc_pkg::PAGE_IDX_W - 1; k >= 0; k--)
            begin
                if (v >= (32'(NUM_PAGES) << k))
                begin
                    v = v - (32'(NUM_PAGES) << k);
                end
            end
            return PW'(v);
        end
    endfunction

    state_t                          state_reg,   state_next;
    logic [PW-1:0]                   clr_reg,     clr_next;
    logic [PW-1:0]                   page_reg,    page_next;
    logic [pdc_pkg::CLIENT_W-1:0]    client_reg,  client_next;
    logic                            mode_reg,    mode_next;
    logic [pdc_pkg::KIND_W-1:0]      pkind_reg,   pkind_next;
    logic [pdc_pkg::CLIENT_W-1:0]    ptarget_reg, ptarget_next;
    logic                            data_reg,    data_next;
    logic                            shared_reg,  shared_next;
    logic                            want_reg,    want_next;
    logic [CW-1:0]                   idx_reg,     idx_next;
    logic [CW-1:0]                   n_reg,       n_next;
    logic [KW-1:0]                   k_reg,       k_next;

    row_t                            rd_row;
    row_t                            app_row;
    row_t                            only_row;
    logic [CW-1:0]                   n_look;
    logic                            listed;
    logic [pdc_pkg::CLIENT_W-1:0]    first_old;
    logic [pdc_pkg::CLIENT_W-1:0]    first_app;
    logic [pdc_pkg::CLIENT_W-1:0]    walk_holder;
    logic                            walk_skip;

    // read data register holds from LOOK through the walk
    assign rd_row = row_t'(mem_rd_data);

    assign n_look = (rd_row.count > CW'(NUM_CLIENTS)) ? CW'(NUM_CLIENTS) : rd_row.count;

    always_comb
    begin
        listed = 1'b0;
        for (int j = 0; j < NUM_CLIENTS; j++)
        begin
            if ((CW'(j) < n_look) && (rd_row.list[j] == client_reg))
            begin
                listed = 1'b1;
            end
        end
    end

    always_comb
    begin
        app_row = rd_row;
        if (!listed && (rd_row.count < CW'(NUM_CLIENTS)))
        begin
            app_row.list[rd_row.count[IW-1:0]] = client_reg;
            app_row.count = rd_row.count + CW'(1);
        end
    end

    always_comb
    begin
        only_row         = rd_row;
        only_row.list[0] = client_reg;
        only_row.count   = CW'(1);
        only_row.status  = pdc_pkg::ST_MODIFIED;
    end

    assign first_old = (rd_row.count != '0) ? rd_row.list[0] : '0;
    assign first_app = (app_row.count != '0) ? app_row.list[0] : '0;

    assign walk_holder = rd_row.list[idx_reg[IW-1:0]];
    assign walk_skip   = (walk_holder == client_reg) ||
                         (k_reg == KW'(pdc_pkg::MAX_PRE_MSGS));

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        page_next    = page_reg;
        client_next  = client_reg;
        mode_next    = mode_reg;
        pkind_next   = pkind_reg;
        ptarget_next = ptarget_reg;
        data_next    = data_reg;
        shared_next  = shared_reg;
        want_next    = want_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        k_next       = k_reg;

        in_ready     = 1'b0;
        msg_valid    = 1'b0;
        msg          = '0;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = page_reduce(in_page);
        mem_wr_en    = 1'b0;
        mem_wr_addr  = page_reg;
        mem_wr_data  = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                if (clr_reg == PW'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + PW'(1);
                end
            end

            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mem_rd_en   = 1'b1;
                    page_next   = page_reduce(in_page);
                    client_next = in_client;
                    mode_next   = in_mode;
                    state_next  = S_LOOK;
                end
            end

            S_LOOK:
            begin
                mem_wr_en  = 1'b1;
                idx_next   = '0;
                k_next     = '0;
                n_next     = n_look;
                want_next  = !listed;
                case (rd_row.status)
                    pdc_pkg::ST_INVALID:
                    begin
                        mem_wr_data        = app_row;
                        mem_wr_data[ROW_W-1 -: pdc_pkg::STATUS_W] = pdc_pkg::ST_MODIFIED;
                        data_next   = 1'b0;
                        shared_next = 1'b0;
                        state_next  = S_REPLY;
                    end
                    pdc_pkg::ST_SHARED:
                    begin
                        if (!mode_reg)
                        begin
                            mem_wr_data  = app_row;
                            pkind_next   = pdc_pkg::KIND_FWD;
                            ptarget_next = first_app;
                            data_next    = 1'b1;
                            shared_next  = 1'b1;
                            state_next   = S_PRE;
                        end
                        else
                        begin
                            mem_wr_data = only_row;
                            data_next   = 1'b0;
                            shared_next = 1'b0;
                            state_next  = (n_look == '0) ? S_REPLY : S_WALK;
                        end
                    end
                    default:
                    begin
                        // modified, and the unused status code alike
                        data_next = 1'b1;
                        if (!mode_reg)
                        begin
                            mem_wr_data  = app_row;
                            mem_wr_data[ROW_W-1 -: pdc_pkg::STATUS_W] = pdc_pkg::ST_SHARED;
                            pkind_next   = pdc_pkg::KIND_FWD;
                            shared_next  = 1'b1;
                        end
                        else
                        begin
                            mem_wr_data  = only_row;
                            pkind_next   = pdc_pkg::KIND_INV_DATA;
                            shared_next  = 1'b0;
                        end
                        ptarget_next = first_old;
                        state_next   = S_PRE;
                    end
                endcase
            end

            S_PRE:
            begin
                msg_valid  = 1'b1;
                msg.kind   = pkind_reg;
                msg.target = ptarget_reg;
                if (msg_ready)
                begin
                    state_next = S_REPLY;
                end
            end

            S_WALK:
            begin
                msg_valid  = !walk_skip;
                msg.kind   = (want_reg && !data_reg) ? pdc_pkg::KIND_INV_DATA
                                                     : pdc_pkg::KIND_INV;
                msg.target = walk_holder;
                if (msg_ready)
                begin
                    if (!walk_skip)
                    begin
                        k_next = k_reg + KW'(1);
                        if (want_reg)
                        begin
                            data_next = 1'b1;
                        end
                    end
                    idx_next = idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) == n_reg)
                    begin
                        state_next = S_REPLY;
                    end
                end
            end

            S_REPLY:
            begin
                msg_valid  = 1'b1;
                msg.kind   = pdc_pkg::KIND_REPLY;
                msg.target = client_reg;
                msg.data   = data_reg;
                msg.shared = shared_reg;
                msg.last   = 1'b1;
                if (msg_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            page_reg    <= '0;
            client_reg  <= '0;
            mode_reg    <= 1'b0;
            pkind_reg   <= pdc_pkg::KIND_FWD;
            ptarget_reg <= '0;
            data_reg    <= 1'b0;
            shared_reg  <= 1'b0;
            want_reg    <= 1'b0;
            idx_reg     <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            page_reg    <= page_next;
            client_reg  <= client_next;
            mode_reg    <= mode_next;
            pkind_reg   <= pkind_next;
            ptarget_reg <= ptarget_next;
            data_reg    <= data_next;
            shared_reg  <= shared_next;
            want_reg    <= want_next;
            idx_reg     <= idx_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/page_directory_coherence.sv
// Top level of the MSI page coherence directory.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  request | in  | s_tvalid/s_tready  | s_tdata: page_index, client_id; s_tuser: mode
//  message | out | m_tvalid/m_tready  | m_tdata: target, data, shared; m_tuser: kind;
//          |     |                    | m_tlast: final reply
//
//  One request at a time. Accept, then row lookup and write-back, then the
//  messages in turn: reads and writes of an invalid page send only the reply,
//  other non-walking requests one message before it, a write to a shared page
//  walks the n listed holders (up to NUM_CLIENTS) before it; the list walk
//  runs over the row memory's read register.
//  After reset a clearing pass writes every page row invalid, during which
//  s_tready stays low.
//  A stalled message sits in the output register; the walk waits on it.
`default_nettype none

module page_directory_coherence #(
    parameter int NUM_PAGES   = pdc_pkg::NUM_PAGES_DEF,
    parameter int NUM_CLIENTS = pdc_pkg::NUM_CLIENTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] page_index, [10:8] client_id, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] mode (0 read, 1 write)
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [2:0] target_client, [3] contains_page,
                                        // [4] shared_grant, rest zero
    output logic [1:0]       m_tuser,   // [1:0] msg_kind
    output logic             m_tlast    // last
);

    localparam int PW    = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CW    = $clog2(NUM_CLIENTS + 1);
    // row: status, holder count, holder list
    localparam int ROW_W = pdc_pkg::STATUS_W + CW + NUM_CLIENTS * pdc_pkg::CLIENT_W;

    logic              mem_rd_en;
    logic [PW-1:0]     mem_rd_addr;
    logic [ROW_W-1:0]  mem_rd_data;
    logic              mem_wr_en;
    logic [PW-1:0]     mem_wr_addr;
    logic [ROW_W-1:0]  mem_wr_data;

    logic              msg_valid;
    logic              msg_ready;
    pdc_pkg::msg_t     msg;

    // output register parts the walk from the consumer
    logic              out_valid_reg;
    pdc_pkg::msg_t     out_msg_reg;

    pdc_store #(
        .NUM_PAGES (NUM_PAGES),
        .ROW_W     (ROW_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    pdc_ctrl #(
        .NUM_PAGES   (NUM_PAGES),
        .NUM_CLIENTS (NUM_CLIENTS),
        .ROW_W       (ROW_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_page     (s_tdata[7:0]),
        .in_client   (s_tdata[10:8]),
        .in_mode     (s_tuser[0]),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .msg         (msg),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    // slot free when empty or being drained this cycle
    assign msg_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_msg_reg   <= '0;
        end
        else if (msg_valid && msg_ready)
        begin
            out_valid_reg <= 1'b1;
            out_msg_reg   <= msg;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_msg_reg.shared, out_msg_reg.data, out_msg_reg.target};
    assign m_tuser  = out_msg_reg.kind;
    assign m_tlast  = out_msg_reg.last;

endmodule

`default_nettype wire

FILE: rtl/core/pdc_checker.sv
// Port-level checks of the page directory and their bind.
`default_nettype none

`include "page_directory_coherence_macros.svh"

module pdc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic [1:0]  m_tuser,
    input wire logic        m_tlast
);

    // stalled message transfer holds its payload
    `PDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled message changed")

    // one request in flight: no second transfer right behind an accepted one
    `PDC_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // coherence messages carry no grant flags and never close the sequence
    `PDC_ASSERT_SAME(a_pre_flags, m_tvalid && (m_tuser != pdc_pkg::KIND_REPLY), !m_tlast && (m_tdata[4:3] == 2'b00), "flags on coherence message")

    // the reply always closes the sequence
    `PDC_ASSERT_SAME(a_reply_last, m_tvalid && (m_tuser == pdc_pkg::KIND_REPLY), m_tlast, "reply without last")

endmodule

bind page_directory_coherence pdc_checker u_pdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

FILE: test/tb_page_directory_coherence.sv
// Self-checking testbench for the page coherence directory: MSI request stream against a predictor.
`timescale 1ns / 100ps

module tb_page_directory_coherence;

    import pdc_pkg::*;

    localparam logic MODE_RD = 1'b0;
    localparam logic MODE_WR = 1'b1;

    localparam int RANDOM_REQS = 256;
    localparam int CALM_REQS   = 40;    // tail of the run with no idling on either side
    localparam int DRAIN_TAIL  = 16;    // cycles after the last message before the verdict

    // Directory predictor plus the queue of messages it still owes.
    class coherence_scoreboard;

        logic [STATUS_W-1:0] page_status [NUM_PAGES_DEF];
        logic [3:0]          holder_count [NUM_PAGES_DEF];
        logic [CLIENT_W-1:0] holder_list [NUM_PAGES_DEF][NUM_CLIENTS_DEF];
        msg_t                expected_msgs [$];
        int                  errors;

        function new();
            errors = 0;
            for (int p = 0; p < NUM_PAGES_DEF; p++)
            begin
                page_status[p]  = ST_INVALID;
                holder_count[p] = '0;
                for (int i = 0; i < NUM_CLIENTS_DEF; i++)
                    holder_list[p][i] = '0;
            end
        endfunction

        function bit listed(logic [7:0] page, logic [CLIENT_W-1:0] client);
            for (int i = 0; i < holder_count[page] && i < NUM_CLIENTS_DEF; i++)
                if (holder_list[page][i] == client)
                    return 1'b1;
            return 1'b0;
        endfunction

        // Append unless already listed or the list is full.
        function void add_holder(logic [7:0] page, logic [CLIENT_W-1:0] client);
            if (listed(page, client) || holder_count[page] >= NUM_CLIENTS_DEF)
                return;
            holder_list[page][holder_count[page][2:0]] = client;
            holder_count[page] = holder_count[page] + 4'd1;
        endfunction

        // An empty list reads as client 0.
        function logic [CLIENT_W-1:0] lead_holder(logic [7:0] page);
            return (holder_count[page] != 0) ? holder_list[page][0] : '0;
        endfunction

        function void queue_msg(logic [KIND_W-1:0] kind, logic [CLIENT_W-1:0] target,
                                logic data, logic shared, logic last);
            msg_t m;
            m.kind   = kind;
            m.target = target;
            m.data   = data;
            m.shared = shared;
            m.last   = last;
            expected_msgs.insert(expected_msgs.size(), m);
        endfunction

        // Called on each accepted request transfer.
        function void note_request(logic [7:0] page, logic [CLIENT_W-1:0] client, logic mode);
            logic [STATUS_W-1:0] st;
            logic                with_data;
            logic                grant_shared;
            logic                needs_data;
            int                  pre_msgs;
            st           = page_status[page];
            with_data    = 1'b0;
            grant_shared = 1'b0;
            pre_msgs     = 0;
            if (st == ST_INVALID)
            begin
                // first touch grants modified, read or write
                page_status[page] = ST_MODIFIED;
                add_holder(page, client);
            end
            else if (st == ST_SHARED && mode == MODE_RD)
            begin
                add_holder(page, client);
                queue_msg(KIND_FWD, lead_holder(page), 1'b0, 1'b0, 1'b0);
                with_data    = 1'b1;
                grant_shared = 1'b1;
            end
            else if (st == ST_SHARED)
            begin
                // data comes back from the first other holder only if requester had no copy
                needs_data = !listed(page, client);
                for (int i = 0; i < holder_count[page] && i < NUM_CLIENTS_DEF; i++)
                begin
                    if (holder_list[page][i] != client && pre_msgs < MAX_PRE_MSGS)
                    begin
                        if (needs_data && !with_data)
                        begin
                            with_data = 1'b1;
                            queue_msg(KIND_INV_DATA, holder_list[page][i], 1'b0, 1'b0, 1'b0);
                        end
                        else
                            queue_msg(KIND_INV, holder_list[page][i], 1'b0, 1'b0, 1'b0);
                        pre_msgs++;
                    end
                end
                page_status[page]    = ST_MODIFIED;
                holder_list[page][0] = client;
                holder_count[page]   = 4'd1;
            end
            else if (mode == MODE_RD)
            begin
                // modified (or stray code three) read: downgrade to shared
                queue_msg(KIND_FWD, lead_holder(page), 1'b0, 1'b0, 1'b0);
                page_status[page] = ST_SHARED;
                add_holder(page, client);
                with_data    = 1'b1;
                grant_shared = 1'b1;
            end
            else
            begin
                // modified write: owner gives up data, even when it is the requester
                queue_msg(KIND_INV_DATA, lead_holder(page), 1'b0, 1'b0, 1'b0);
                page_status[page]    = ST_MODIFIED;
                holder_list[page][0] = client;
                holder_count[page]   = 4'd1;
                with_data = 1'b1;
            end
            queue_msg(KIND_REPLY, client, with_data, grant_shared, 1'b1);
        endfunction

        // Called on each accepted message transfer.
        function void check_msg(msg_t got);
            msg_t want;
            if (expected_msgs.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected message: kind=%0d target=%0d",
                             got.kind, got.target,
                             " data=%b shared=%b last=%b",
                             got.data, got.shared, got.last);
                return;
            end
            want = expected_msgs.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("message mismatch: exp kind=%0d target=%0d",
                             want.kind, want.target,
                             " data=%b shared=%b last=%b,",
                             want.data, want.shared, want.last,
                             " got kind=%0d target=%0d",
                             got.kind, got.target,
                             " data=%b shared=%b last=%b",
                             got.data, got.shared, got.last);
            end
        endfunction

    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;      // [7:0] page_index, [10:8] client_id, rest zero
    logic [0:0]  s_tuser = '0;      // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [2:0] target_client, [3] contains_page, [4] shared_grant
    logic [1:0]  m_tuser;           // [1:0] msg_kind
    logic        m_tlast;

    // set for the tail of the run: both sides stop idling
    bit calm = 1'b0;

    coherence_scoreboard sb = new();

    page_directory_coherence dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // Message monitor: every transfer on the master side goes to the scoreboard.
    always @(posedge clk)
    begin
        msg_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind   = m_tuser;
            got.target = m_tdata[2:0];
            got.data   = m_tdata[3];
            got.shared = m_tdata[4];
            got.last   = m_tlast;
            sb.check_msg(got);
        end
    end

    // Present one request and hold it until the transfer; tvalid is left high.
    task automatic send_request(input logic [7:0] page, input logic [2:0] client,
                                input logic mode);
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, client, page};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(page, client, mode);
    endtask

    // Random sender gap; idle cycles carry junk on the data lines.
    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 15);
            repeat (n)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= {5'b0, 11'($urandom)};
                s_tuser  <= 1'($urandom);
            end
        end
    endtask

    // Drop tvalid and hold off until every owed message has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_msgs.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: runs of ready, broken by random stall bursts.
    initial
    begin : sink_drive
        int n;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 20);
            repeat (n)
            begin
                @(negedge clk);
                m_tready <= 1'b1;
            end
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                n = $urandom_range(1, 15);
                repeat (n)
                begin
                    @(negedge clk);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0] page;
        logic [2:0] client;
        logic       mode;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Page 0 walks through every state and fills its list.
        send_request(8'h00, 3'd0, MODE_RD);     // invalid read still grants modified
        send_request(8'hFF, 3'd7, MODE_WR);     // invalid write, top page and client
        send_request(8'h00, 3'd3, MODE_RD);     // modified read: forward, downgrade
        send_request(8'h00, 3'd3, MODE_RD);     // shared read by a listed client
        send_request(8'h00, 3'd1, MODE_RD);
        send_request(8'h00, 3'd2, MODE_RD);
        send_request(8'h00, 3'd4, MODE_RD);
        send_request(8'h00, 3'd5, MODE_RD);
        send_request(8'h00, 3'd6, MODE_RD);
        send_request(8'h00, 3'd7, MODE_RD);     // list now full
        send_request(8'h00, 3'd0, MODE_RD);     // full list, duplicate
        send_request(8'h00, 3'd5, MODE_WR);     // seven invalidates, none with data
        send_request(8'h00, 3'd5, MODE_WR);     // modified write by the owner itself
        send_request(8'hFF, 3'd0, MODE_WR);     // modified write by another client
        send_request(8'h55, 3'd2, MODE_WR);
        send_request(8'h55, 3'd4, MODE_RD);
        send_request(8'h55, 3'd6, MODE_RD);
        send_request(8'h55, 3'd1, MODE_WR);     // unlisted writer: first holder returns data
        send_request(8'hAA, 3'd7, MODE_RD);
        send_request(8'hAA, 3'd7, MODE_RD);     // forward to the requester itself
        send_request(8'hAA, 3'd7, MODE_WR);     // sole sharer upgrades, no invalidates
        send_request(8'hAA, 3'd3, MODE_RD);
        send_request(8'hAA, 3'd3, MODE_WR);     // listed writer, one plain invalidate

        hold_until_drained();

        // Random part: mostly a handful of hot pages so lists grow and states churn,
        // with the odd request to anywhere in the directory.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            if (i == RANDOM_REQS / 2)
                hold_until_drained();
            if (i == RANDOM_REQS - CALM_REQS)
                calm = 1'b1;
            if ($urandom_range(0, 3) != 0)
                page = 8'($urandom_range(0, 5) * 51);
            else
                page = 8'($urandom_range(0, 255));
            client = 3'($urandom_range(0, 7));
            mode   = ($urandom_range(0, 2) == 0) ? MODE_WR : MODE_RD;
            sender_gap();
            send_request(page, client, mode);
        end

        hold_until_drained();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (sb.errors == 0 && sb.expected_msgs.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
